>>> hdl/ioe_pkg.sv
// Package for the indexed ordered list engine: sizes, command and status
// codes, controller states and the request and response structs.
// No dependencies.
package ioe_pkg;

  // Store geometry
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned CMD_W    = 4;
  localparam int unsigned ST_W     = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_TAIL = 4'd0,
    CMD_PUSH_HEAD = 4'd1,
    CMD_INSERT_AT = 4'd2,
    CMD_SORTED    = 4'd3,
    CMD_READ_AT   = 4'd4,
    CMD_DEL_HEAD  = 4'd5,
    CMD_DEL_TAIL  = 4'd6,
    CMD_DEL_AT    = 4'd7,
    CMD_DEL_VALUE = 4'd8,
    CMD_MIDDLE    = 4'd9
  } ioe_cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_POS   = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } ioe_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_READ,
    S_RESP
  } ioe_state_e;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [CNT_W-1:0]        position;
    logic signed [VAL_W-1:0] item_value;
  } ioe_req_t;

  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] read_value;
    logic [CNT_W-1:0]        count_now;
  } ioe_rsp_t;

endpackage

>>> hdl/ioe_ram.sv
// Generic simple dual-port RAM: one write port and one read port with a
// registered read. No dependencies.
module ioe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/indexed_ordered_list_engine.sv
// Top level of the indexed ordered list engine: a contiguous list kept in one
// RAM, with a controller that searches and shifts entries one per cycle.
// Depends on ioe_pkg and ioe_ram.
//
//   Channel | Signals                               | Direction
//   --------+---------------------------------------+----------
//   request | req_valid_i, req_ready_o, req_i       | in
//   response| rsp_valid_o, rsp_ready_i, rsp_o       | out
//
// One request is worked on at a time; the next is taken once the previous
// response sits in the output register. Inserts and deletes move one entry
// per cycle through the RAM port. Reset clears the control state and the
// count; the RAM needs no clearing. A stalled response holds the controller
// in its response state until the output register is free.
module indexed_ordered_list_engine
  import ioe_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  ioe_req_t req_i,
  output logic     rsp_valid_o,
  input  logic     rsp_ready_i,
  output ioe_rsp_t rsp_o
);

  ioe_state_e state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  pos_q, pos_d;
  logic [CNT_W-1:0]  src_q, src_d;
  logic [ADDR_W-1:0] dst_q, dst_d;
  logic              pend_q, pend_d;
  logic              more_q, more_d;
  logic              right_q, right_d;
  logic              sorted_q, sorted_d;
  logic signed [VAL_W-1:0] val_q, val_d;
  logic signed [VAL_W-1:0] res_value_q, res_value_d;
  ioe_status_e       res_status_q, res_status_d;
  ioe_rsp_t          out_q;
  logic              out_valid_q;
  logic              load_out;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [VAL_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [VAL_W-1:0]  ram_rdata;

  logic              go_shift;
  logic [CNT_W-1:0]  go_pos;
  logic              go_right;
  logic              full;
  logic              empty;
  logic              hit;
  logic [CNT_W-1:0]  lim;

  assign full  = (count_q == CNT_W'(CAPACITY));
  assign empty = (count_q == '0);

  // Search match: first entry not less than the value, or an equal entry.
  assign hit = sorted_q ? !($signed(ram_rdata) < val_q) : ($signed(ram_rdata) == val_q);

  // Last source index of a shift run.
  assign lim = right_q ? pos_q : (count_q - CNT_W'(1));

  // List storage.
  ioe_ram #(
    .WIDTH(VAL_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Next state and datapath control.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    pos_d        = pos_q;
    src_d        = src_q;
    dst_d        = dst_q;
    pend_d       = pend_q;
    more_d       = more_q;
    right_d      = right_q;
    sorted_d     = sorted_q;
    val_d        = val_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    ram_we       = 1'b0;
    ram_waddr    = dst_q;
    ram_wdata    = ram_rdata;
    ram_raddr    = src_q[ADDR_W-1:0];
    go_shift     = 1'b0;
    go_pos       = pos_q;
    go_right     = right_q;
    req_ready_o  = 1'b0;
    load_out     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        ram_raddr   = req_i.position[ADDR_W-1:0];
        if (req_valid_i) begin
          val_d        = req_i.item_value;
          pos_d        = req_i.position;
          res_value_d  = '0;
          res_status_d = ST_OK;
          state_d      = S_RESP;
          unique case (ioe_cmd_e'(req_i.cmd))
            CMD_PUSH_TAIL: begin
              if (full) begin
                res_status_d = ST_FULL;
              end else begin
                go_shift = 1'b1;
                go_pos   = count_q;
                go_right = 1'b1;
              end
            end
            CMD_PUSH_HEAD: begin
              if (full) begin
                res_status_d = ST_FULL;
              end else begin
                go_shift = 1'b1;
                go_pos   = '0;
                go_right = 1'b1;
              end
            end
            CMD_INSERT_AT: begin
              if (req_i.position > count_q) begin
                res_status_d = ST_BAD_POS;
              end else if (full) begin
                res_status_d = ST_FULL;
              end else begin
                go_shift = 1'b1;
                go_pos   = req_i.position;
                go_right = 1'b1;
              end
            end
            CMD_SORTED: begin
              if (full) begin
                res_status_d = ST_FULL;
              end else begin
                state_d  = S_SEARCH;
                sorted_d = 1'b1;
                src_d    = '0;
                pend_d   = 1'b0;
              end
            end
            CMD_READ_AT: begin
              if (req_i.position >= count_q) begin
                res_status_d = ST_BAD_POS;
              end else begin
                state_d = S_READ;
              end
            end
            CMD_DEL_HEAD: begin
              if (empty) begin
                res_status_d = ST_EMPTY;
              end else begin
                go_shift = 1'b1;
                go_pos   = '0;
                go_right = 1'b0;
              end
            end
            CMD_DEL_TAIL: begin
              if (empty) begin
                res_status_d = ST_EMPTY;
              end else begin
                go_shift = 1'b1;
                go_pos   = count_q - CNT_W'(1);
                go_right = 1'b0;
              end
            end
            CMD_DEL_AT: begin
              if (empty) begin
                res_status_d = ST_EMPTY;
              end else if (req_i.position >= count_q) begin
                res_status_d = ST_BAD_POS;
              end else begin
                go_shift = 1'b1;
                go_pos   = req_i.position;
                go_right = 1'b0;
              end
            end
            CMD_DEL_VALUE: begin
              if (empty) begin
                res_status_d = ST_EMPTY;
              end else begin
                state_d  = S_SEARCH;
                sorted_d = 1'b0;
                src_d    = '0;
                pend_d   = 1'b0;
              end
            end
            CMD_MIDDLE: begin
              if (empty) begin
                res_status_d = ST_EMPTY;
              end else begin
                ram_raddr = ADDR_W'(count_q >> 1);
                state_d   = S_READ;
              end
            end
            default: begin
              res_status_d = ST_OK;
            end
          endcase
        end
      end

      // Walk the list from the head, comparing each entry in the cycle after its read.
      S_SEARCH: begin
        if (pend_q && hit) begin
          go_shift = 1'b1;
          go_pos   = CNT_W'(dst_q);
          go_right = sorted_q;
        end else if (src_q < count_q) begin
          ram_raddr = src_q[ADDR_W-1:0];
          dst_d     = src_q[ADDR_W-1:0];
          src_d     = src_q + CNT_W'(1);
          pend_d    = 1'b1;
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else if (sorted_q) begin
          go_shift = 1'b1;
          go_pos   = count_q;
          go_right = 1'b1;
        end else begin
          res_status_d = ST_NOT_FOUND;
          state_d      = S_RESP;
        end
      end

      // Move entries one place, one read and one write-back per cycle.
      S_SHIFT: begin
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = dst_q;
          ram_wdata = ram_rdata;
        end
        if (more_q) begin
          ram_raddr = src_q[ADDR_W-1:0];
          pend_d    = 1'b1;
          dst_d     = right_q ? ADDR_W'(src_q + CNT_W'(1)) : ADDR_W'(src_q - CNT_W'(1));
          if (src_q == lim) begin
            more_d = 1'b0;
          end else begin
            src_d = right_q ? (src_q - CNT_W'(1)) : (src_q + CNT_W'(1));
          end
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          // Run finished: place the new value or drop the tail.
          if (right_q) begin
            ram_we    = 1'b1;
            ram_waddr = pos_q[ADDR_W-1:0];
            ram_wdata = val_q;
            count_d   = count_q + CNT_W'(1);
          end else begin
            count_d = count_q - CNT_W'(1);
          end
          state_d = S_RESP;
        end
      end

      S_READ: begin
        res_value_d = $signed(ram_rdata);
        state_d     = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_q || rsp_ready_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Start a shift run: inserts walk down from the tail, deletes walk up.
    if (go_shift) begin
      state_d = S_SHIFT;
      pos_d   = go_pos;
      right_d = go_right;
      pend_d  = 1'b0;
      if (go_right) begin
        src_d  = count_q - CNT_W'(1);
        more_d = (go_pos != count_q);
      end else begin
        src_d  = go_pos + CNT_W'(1);
        more_d = (go_pos != (count_q - CNT_W'(1)));
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      more_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      more_q  <= more_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    src_q        <= src_d;
    dst_q        <= dst_d;
    right_q      <= right_d;
    sorted_q     <= sorted_d;
    val_q        <= val_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    if (load_out) begin
      out_q.status     <= res_status_q;
      out_q.read_value <= res_value_q;
      out_q.count_now  <= count_q;
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the indexed ordered list engine: directed and
// phased random list commands, each response checked against a queue-based list.
// Depends on ioe_pkg and the indexed_ordered_list_engine RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ioe_pkg::*;

  localparam int unsigned IDLE_LIMIT     = 3000;
  localparam int unsigned HOLDOFF_CYCLES = 400;
  localparam int unsigned ITEM_TARGET    = 1950;
  localparam int unsigned POS_MAX        = (1 << CNT_W) - 1;
  localparam int unsigned CMD_MAX        = (1 << CMD_W) - 1;
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  typedef enum int {PH_FILL, PH_GROW, PH_SHRINK, PH_MIXED} phase_kind_e;
  typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_EVERY_THIRD, RDY_SPARSE} ready_mode_e;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     req_valid_i = 1'b0;
  logic     req_ready_o;
  ioe_req_t req_i       = '0;
  logic     rsp_valid_o;
  logic     rsp_ready_i = 1'b0;
  ioe_rsp_t rsp_o;

  // List contents as the engine should hold them, head at index 0
  logic signed [VAL_W-1:0] list_contents[$];
  ioe_req_t    pending_reqs[$];
  ioe_rsp_t    expected_rsps[$];

  int unsigned planned_count;
  int unsigned reqs_accepted;
  int unsigned rsps_seen;
  int unsigned fail_count;
  int unsigned peak_len;
  int unsigned status_tally [1 << ST_W];

  indexed_ordered_list_engine u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o)
  );

  // Clock and a single reset pulse at the start
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Apply one command to the list and return the response it must produce.
  function automatic ioe_rsp_t apply_list_command(ioe_req_t r);
    ioe_rsp_t                rsp;
    logic signed [VAL_W-1:0] v;
    int unsigned             n;
    int unsigned             idx;
    rsp        = '0;
    rsp.status = ST_OK;
    v          = $signed(r.item_value);
    n          = list_contents.size();
    case (r.cmd)
      CMD_PUSH_TAIL: begin
        if (n >= CAPACITY) rsp.status = ST_FULL;
        else list_contents.push_back(v);
      end
      CMD_PUSH_HEAD: begin
        if (n >= CAPACITY) rsp.status = ST_FULL;
        else list_contents.push_front(v);
      end
      CMD_INSERT_AT: begin
        if (r.position > n) rsp.status = ST_BAD_POS;
        else if (n >= CAPACITY) rsp.status = ST_FULL;
        else list_contents.insert(r.position, v);
      end
      CMD_SORTED: begin
        if (n >= CAPACITY) begin
          rsp.status = ST_FULL;
        end else begin
          // New value goes before the first entry that is not less than it
          idx = 0;
          while (idx < n && list_contents[idx] < v) idx++;
          list_contents.insert(idx, v);
        end
      end
      CMD_READ_AT: begin
        if (r.position >= n) rsp.status = ST_BAD_POS;
        else rsp.read_value = list_contents[r.position];
      end
      CMD_DEL_HEAD: begin
        if (n == 0) rsp.status = ST_EMPTY;
        else void'(list_contents.pop_front());
      end
      CMD_DEL_TAIL: begin
        if (n == 0) rsp.status = ST_EMPTY;
        else void'(list_contents.pop_back());
      end
      CMD_DEL_AT: begin
        if (n == 0) rsp.status = ST_EMPTY;
        else if (r.position >= n) rsp.status = ST_BAD_POS;
        else list_contents.delete(r.position);
      end
      CMD_DEL_VALUE: begin
        if (n == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          idx = 0;
          while (idx < n && list_contents[idx] != v) idx++;
          if (idx >= n) rsp.status = ST_NOT_FOUND;
          else list_contents.delete(idx);
        end
      end
      CMD_MIDDLE: begin
        if (n == 0) rsp.status = ST_EMPTY;
        else rsp.read_value = list_contents[n / 2];
      end
      default: begin
        // Unused command codes leave the list alone and answer ok
      end
    endcase
    rsp.count_now = CNT_W'(list_contents.size());
    if (list_contents.size() > peak_len) peak_len = list_contents.size();
    return rsp;
  endfunction

  function automatic void report_failure(string what);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] %s", $realtime, what);
  endfunction

  // Compare one accepted response with the oldest outstanding expectation.
  function automatic void check_response(ioe_rsp_t got);
    ioe_rsp_t want;
    rsps_seen++;
    status_tally[got.status]++;
    if (expected_rsps.size() == 0) begin
      report_failure($sformatf("unexpected response: status %0d value %0d count %0d",
                               got.status, $signed(got.read_value), got.count_now));
      return;
    end
    want = expected_rsps.pop_front();
    if (got.status !== want.status || got.read_value !== want.read_value ||
        got.count_now !== want.count_now) begin
      report_failure($sformatf(
        "response %0d: expected status %0d value %0d count %0d, got %0d %0d %0d",
        rsps_seen, want.status, $signed(want.read_value), want.count_now,
        got.status, $signed(got.read_value), got.count_now));
    end
  endfunction

  // Stimulus planning keeps a rough idea of the list length so that
  // positions land mostly inside the list.
  int unsigned est_count;

  function automatic void plan_request(logic [CMD_W-1:0] cmd, logic [CNT_W-1:0] pos,
                                       logic signed [VAL_W-1:0] val);
    ioe_req_t r;
    r.cmd        = cmd;
    r.position   = pos;
    r.item_value = val;
    pending_reqs.push_back(r);
    if (cmd <= CMD_MIDDLE) planned_count++;
    case (cmd)
      CMD_PUSH_TAIL, CMD_PUSH_HEAD, CMD_SORTED: begin
        if (est_count < CAPACITY) est_count++;
      end
      CMD_INSERT_AT: begin
        if (pos <= est_count && est_count < CAPACITY) est_count++;
      end
      CMD_DEL_HEAD, CMD_DEL_TAIL: begin
        if (est_count != 0) est_count--;
      end
      CMD_DEL_AT: begin
        if (pos < est_count) est_count--;
      end
      CMD_DEL_VALUE: begin
        // Small values are usually present somewhere in the list
        if (est_count != 0 && val >= -8 && val <= 8) est_count--;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    int unsigned w;
    int          near_zero;
    w = $urandom_range(0, 9);
    if (w < 6) begin
      near_zero = int'($urandom_range(0, 16)) - 8;
      return near_zero;
    end
    if (w == 6) begin
      case ($urandom_range(0, 3))
        0:       return VAL_MIN;
        1:       return VAL_MAX;
        2:       return '0;
        default: return '1;
      endcase
    end
    return $urandom();
  endfunction

  function automatic logic [CNT_W-1:0] pick_position();
    int unsigned w;
    int unsigned p;
    w = $urandom_range(0, 9);
    if (w < 8) return CNT_W'($urandom_range(0, est_count));
    if (w == 8) begin
      p = est_count + $urandom_range(1, 3);
      return CNT_W'((p > POS_MAX) ? POS_MAX : p);
    end
    return CNT_W'($urandom_range(0, POS_MAX));
  endfunction

  function automatic logic [CMD_W-1:0] pick_command(phase_kind_e kind);
    int unsigned w;
    int unsigned insert_pct;
    int unsigned read_pct;
    w = $urandom_range(0, 99);
    if (w < 2) return CMD_W'($urandom_range(int'(CMD_MIDDLE) + 1, CMD_MAX));
    case (kind)
      PH_FILL:   begin insert_pct = 95; read_pct = 3;  end
      PH_GROW:   begin insert_pct = 70; read_pct = 18; end
      PH_SHRINK: begin insert_pct = 10; read_pct = 20; end
      default:   begin insert_pct = 40; read_pct = 20; end
    endcase
    w = $urandom_range(0, 99);
    if (w < insert_pct) begin
      return CMD_W'($urandom_range(int'(CMD_PUSH_TAIL), int'(CMD_SORTED)));
    end
    if (w < insert_pct + read_pct) return $urandom_range(0, 1) ? CMD_READ_AT : CMD_MIDDLE;
    return CMD_W'($urandom_range(int'(CMD_DEL_HEAD), int'(CMD_DEL_VALUE)));
  endfunction

  task automatic wait_until_drained();
    while (pending_reqs.size() != 0 || req_valid_i || expected_rsps.size() != 0)
      @(posedge clk_i);
  endtask

  // Request driver: bursts of requests separated by random gaps
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    logic     next_valid;
    ioe_req_t next_req;
    if (!rst_ni) begin
      req_valid_i <= 1'b0;
      req_i       <= '0;
      burst_left  = 1;
      gap_left    = 0;
    end else begin
      next_valid = req_valid_i;
      next_req   = req_i;
      if (req_valid_i && req_ready_o) begin
        expected_rsps.push_back(apply_list_command(req_i));
        reqs_accepted++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_reqs.size() != 0) begin
          next_req   = pending_reqs.pop_front();
          next_valid = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 3))
              0:       gap_left = 0;
              1:       gap_left = $urandom_range(20, 60);
              default: gap_left = $urandom_range(1, 4);
            endcase
          end else begin
            burst_left--;
          end
        end
      end
      req_valid_i <= next_valid;
      req_i       <= next_req;
    end
  end

  // Response monitor and receiver stall pattern, with two long hold-offs
  // taken while requests are still queued so that the engine backs up.
  int unsigned holdoff_left;
  int unsigned holdoffs_done;
  int unsigned stretch_left;
  int unsigned pattern_phase;
  ready_mode_e ready_mode;

  always @(posedge clk_i or negedge rst_ni) begin
    logic next_ready;
    if (!rst_ni) begin
      rsp_ready_i   <= 1'b0;
      holdoff_left  = 0;
      holdoffs_done = 0;
      stretch_left  = 0;
      pattern_phase = 0;
      ready_mode    = RDY_ALWAYS;
    end else begin
      if (rsp_valid_o && rsp_ready_i) check_response(rsp_o);
      pattern_phase = (pattern_phase + 1) % 3;
      if (holdoff_left != 0) begin
        holdoff_left--;
        next_ready = 1'b0;
      end else if (holdoffs_done < 2 && rsps_seen >= 300 + 900 * holdoffs_done &&
                   pending_reqs.size() > 4) begin
        holdoff_left = HOLDOFF_CYCLES;
        holdoffs_done++;
        next_ready = 1'b0;
      end else begin
        if (stretch_left == 0) begin
          ready_mode   = ready_mode_e'($urandom_range(0, 3));
          stretch_left = $urandom_range(10, 150);
        end else begin
          stretch_left--;
        end
        case (ready_mode)
          RDY_ALWAYS:      next_ready = 1'b1;
          RDY_COIN:        next_ready = 1'($urandom_range(0, 1));
          RDY_EVERY_THIRD: next_ready = (pattern_phase == 0);
          default:         next_ready = ($urandom_range(0, 4) == 0);
        endcase
      end
      rsp_ready_i <= next_ready;
    end
  end

  // Watchdog: too long without any handshake on either channel
  int unsigned idle_cycles;

  always @(posedge clk_i) begin
    if ((req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i)) begin
      idle_cycles = 0;
    end else if (rst_ni) begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no request or response moved for %0d cycles", IDLE_LIMIT);
        $display("** indexed_ordered_list_engine: FAILED **");
        $finish;
      end
    end
  end

  // Stimulus: directed corner cases, then phased random traffic
  initial begin
    phase_kind_e kind;
    int unsigned phase_no;
    int unsigned len;
    logic [CMD_W-1:0] c;

    // Every delete and read on an empty list, then a bad insert position
    plan_request(CMD_DEL_HEAD,  0, 0);
    plan_request(CMD_DEL_TAIL,  0, 0);
    plan_request(CMD_DEL_AT,    0, 0);
    plan_request(CMD_DEL_VALUE, 0, 0);
    plan_request(CMD_MIDDLE,    0, 0);
    plan_request(CMD_READ_AT,   0, 0);
    plan_request(CMD_INSERT_AT, 1, 5);
    // Build a short list with the value extremes
    plan_request(CMD_PUSH_TAIL, 0, VAL_MIN);
    plan_request(CMD_PUSH_HEAD, 0, VAL_MAX);
    plan_request(CMD_INSERT_AT, 2, 0);
    plan_request(CMD_INSERT_AT, 1, -1);
    plan_request(CMD_SORTED,    0, 5);
    plan_request(CMD_SORTED,    0, VAL_MIN);
    plan_request(CMD_SORTED,    0, VAL_MAX);
    plan_request(CMD_READ_AT,   3, 0);
    plan_request(CMD_READ_AT,   CNT_W'(POS_MAX), 0);
    plan_request(CMD_MIDDLE,    0, 0);
    plan_request(CMD_DEL_VALUE, 0, 0);
    plan_request(CMD_DEL_VALUE, 0, 12345);
    plan_request(CMD_DEL_AT,    CNT_W'(POS_MAX), 0);
    plan_request(CMD_DEL_AT,    1, 0);
    plan_request(CMD_DEL_HEAD,  0, 0);
    plan_request(CMD_DEL_TAIL,  0, 0);
    plan_request(CMD_W'(CMD_MAX), CNT_W'(POS_MAX), -1);
    plan_request(CMD_W'(int'(CMD_MIDDLE) + 1), 0, 0);

    // The first phase fills the store so that full refusals appear early
    phase_no = 0;
    while (planned_count < ITEM_TARGET) begin
      kind = (phase_no == 0) ? PH_FILL : phase_kind_e'($urandom_range(0, 3));
      len  = (phase_no == 0) ? 90 : $urandom_range(20, 120);
      repeat (len) begin
        c = pick_command(kind);
        plan_request(c, pick_position(), pick_value());
      end
      phase_no++;
      // Every fourth phase the sender waits for all responses and the
      // length estimate is brought back in line with the list.
      if (phase_no % 4 == 0) begin
        wait_until_drained();
        est_count = list_contents.size();
      end else begin
        while (pending_reqs.size() > 3) @(posedge clk_i);
      end
    end

    wait_until_drained();
    repeat (2 * CAPACITY) @(posedge clk_i);

    $display("Run: %0d requests, %0d responses, list length peaked at %0d of %0d.",
             reqs_accepted, rsps_seen, peak_len, CAPACITY);
    $display("Statuses: ok %0d, bad position %0d, empty %0d, not found %0d, full %0d.",
             status_tally[ST_OK], status_tally[ST_BAD_POS], status_tally[ST_EMPTY],
             status_tally[ST_NOT_FOUND], status_tally[ST_FULL]);
    if (fail_count == 0) begin
      $display("** indexed_ordered_list_engine: PASSED **");
    end else begin
      $display("%0d mismatches in total", fail_count);
      $display("** indexed_ordered_list_engine: FAILED **");
    end
    $finish;
  end

endmodule
